/* rtl/core/fsq_pkg.sv */
`timescale 1ns / 1ps

package fsq_pkg;

   // packet header
   localparam int HDR_BYTES = 5;
   localparam int HDR_TYPE  = 0;
   localparam int HDR_SEQ   = 1;
   localparam int HDR_IDX   = 2;
   localparam int HDR_TOT   = 3;

   // command field widths, sized for the largest supported configuration
   localparam int CMD_SLOT_W = 5;   // up to 32 frame slots
   localparam int CMD_OFF_W  = 12;  // up to 4096 bytes per frame
   localparam int DLEN_W     = 6;   // up to 63 data bytes per packet
   localparam int CMD_DEPTH  = 2;   // front-to-back command queue

   localparam logic [7:0] PTYPE_RESET = 8'd1;

   // request codes
   localparam logic REQ_DATA    = 1'b0;
   localparam logic REQ_TX_DONE = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_FULL   = 2'd2;
   localparam logic [1:0] KIND_LONG   = 2'd3;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_payload_type;

   typedef struct packed {
      logic                  has_status;
      logic [1:0]            status_kind;
      logic                  has_pkt;
      logic [CMD_SLOT_W-1:0] slot;
      logic [CMD_OFF_W-1:0]  offset;
      logic [DLEN_W-1:0]     dlen;
      logic [7:0]            chunk_idx;
      logic [7:0]            chunk_tot;
      logic [7:0]            seq;
   } cmd_type;

   typedef struct packed {
      logic                  en;
      logic [CMD_SLOT_W-1:0] slot;
      logic [CMD_OFF_W-1:0]  offset;
      logic [7:0]            data;
   } store_wr_type;

   typedef struct packed {
      logic                  en;
      logic [CMD_SLOT_W-1:0] slot;
      logic [CMD_OFF_W-1:0]  offset;
   } store_rd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_STATUS,
      BK_PKT
   } back_state_type;

endpackage

/* rtl/core/fsq_store.sv */
`timescale 1ns / 1ps

module fsq_store #(
   parameter int QUEUE_DEPTH     = 4,
   parameter int MAX_FRAME_BYTES = 1024
) (
   input  logic                  clock,
   input  fsq_pkg::store_wr_type wr,
   input  fsq_pkg::store_rd_type rd,
   output logic [7:0]            rd_data
);

   localparam int SLOT_W = $clog2(QUEUE_DEPTH + 2);
   localparam int OFF_W  = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
   localparam int DEPTH  = (QUEUE_DEPTH + 2) * (2 ** OFF_W);

   logic [7:0]              store_ff [DEPTH];
   logic [7:0]              rd_data_ff;
   logic [SLOT_W+OFF_W-1:0] wr_addr;
   logic [SLOT_W+OFF_W-1:0] rd_addr;

   assign wr_addr = {wr.slot[SLOT_W-1:0], wr.offset[OFF_W-1:0]};
   assign rd_addr = {rd.slot[SLOT_W-1:0], rd.offset[OFF_W-1:0]};
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr_addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

endmodule

/* rtl/core/fsq_cmd_fifo.sv */
`timescale 1ns / 1ps

module fsq_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fsq_pkg::cmd_type push_data,
   input  logic             pop,
   output fsq_pkg::cmd_type pop_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (fsq_pkg::CMD_DEPTH > 1) ? $clog2(fsq_pkg::CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(fsq_pkg::CMD_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(fsq_pkg::CMD_DEPTH - 1);

   fsq_pkg::cmd_type entries_ff [fsq_pkg::CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(fsq_pkg::CMD_DEPTH));
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/fsq_front.sv */
`timescale 1ns / 1ps

module fsq_front #(
   parameter int DATA_BYTES      = 32,
   parameter int QUEUE_DEPTH     = 4,
   parameter int MAX_FRAME_BYTES = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fsq_pkg::req_payload_type req_payload,
   input  logic                     cmd_full,
   input  logic                     cmd_empty,
   input  logic                     back_idle,
   output logic                     cmd_push,
   output fsq_pkg::cmd_type         cmd_data,
   output fsq_pkg::store_wr_type    store_wr
);

   localparam int SLOT_W = $clog2(QUEUE_DEPTH + 2);
   localparam int RING_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int LEN_W  = $clog2(MAX_FRAME_BYTES + 1);
   localparam int OFF_W  = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
   localparam int SUM_W  = $clog2(MAX_FRAME_BYTES + DATA_BYTES + 1);
   localparam int SUB_W  = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
   localparam int DL_W   = $clog2(DATA_BYTES + 1);

   // slot ids: staging, active, queued frames and a pool of free slots
   logic [SLOT_W-1:0] stage_slot_ff, stage_slot_in;
   logic [SLOT_W-1:0] active_slot_ff, active_slot_in;
   logic [SLOT_W-1:0] q_slot_ff [QUEUE_DEPTH];
   logic [SLOT_W-1:0] q_slot_in [QUEUE_DEPTH];
   logic [LEN_W-1:0]  q_len_ff  [QUEUE_DEPTH];
   logic [LEN_W-1:0]  q_len_in  [QUEUE_DEPTH];
   logic [7:0]        q_tot_ff  [QUEUE_DEPTH];
   logic [7:0]        q_tot_in  [QUEUE_DEPTH];
   logic [SLOT_W-1:0] free_ff   [QUEUE_DEPTH];
   logic [SLOT_W-1:0] free_in   [QUEUE_DEPTH];
   logic [CNT_W-1:0]  q_count_ff, q_count_in;

   // frame being sent
   logic              sending_ff, sending_in;
   logic [7:0]        chunk_idx_ff, chunk_idx_in;
   logic [7:0]        chunk_tot_ff, chunk_tot_in;
   logic [LEN_W-1:0]  act_len_ff, act_len_in;
   logic [OFF_W-1:0]  offset_ff, offset_in;
   logic [7:0]        seq_ff, seq_in;

   // frame being loaded
   logic [LEN_W-1:0]  load_count_ff, load_count_in;
   logic [SUB_W-1:0]  load_sub_ff, load_sub_in;
   logic [7:0]        load_chunks_ff, load_chunks_in;
   logic              load_over_ff, load_over_in;

   // staging slot may still be read by the back end
   logic              hazard_ff, hazard_in;

   logic              fire;
   logic              is_data;
   logic              room;
   logic              swap;
   logic [LEN_W-1:0]  len_now;
   logic [7:0]        chunks_now;
   logic              over_now;
   logic [SUM_W-1:0]  next_off;
   logic [7:0]        seq_next;
   logic [RING_W-1:0] push_idx;
   logic [CNT_W-1:0]  free_cnt;

   function automatic logic [DL_W-1:0] chunk_len(input logic [LEN_W-1:0] len,
                                                 input logic [SUM_W-1:0] off);
      logic [SUM_W-1:0] rem;
      rem = SUM_W'(len) - off;
      if (rem > SUM_W'(DATA_BYTES)) begin
         chunk_len = DL_W'(DATA_BYTES);
      end else begin
         chunk_len = DL_W'(rem);
      end
   endfunction

   assign is_data   = (req_payload.req_type == fsq_pkg::REQ_DATA);
   assign req_ready = !cmd_full && !(is_data && hazard_ff);
   assign fire      = req_valid && req_ready;
   assign room      = (load_count_ff < LEN_W'(MAX_FRAME_BYTES));
   assign next_off  = SUM_W'(offset_ff) + SUM_W'(DATA_BYTES);
   assign seq_next  = seq_ff + 8'd1;
   assign push_idx  = q_count_ff[RING_W-1:0];
   assign free_cnt  = CNT_W'(QUEUE_DEPTH) - q_count_ff;

   always_comb begin
      stage_slot_in  = stage_slot_ff;
      active_slot_in = active_slot_ff;
      q_slot_in      = q_slot_ff;
      q_len_in       = q_len_ff;
      q_tot_in       = q_tot_ff;
      free_in        = free_ff;
      q_count_in     = q_count_ff;
      sending_in     = sending_ff;
      chunk_idx_in   = chunk_idx_ff;
      chunk_tot_in   = chunk_tot_ff;
      act_len_in     = act_len_ff;
      offset_in      = offset_ff;
      seq_in         = seq_ff;
      load_count_in  = load_count_ff;
      load_sub_in    = load_sub_ff;
      load_chunks_in = load_chunks_ff;
      load_over_in   = load_over_ff;
      swap           = 1'b0;
      len_now        = load_count_ff;
      chunks_now     = load_chunks_ff;
      over_now       = load_over_ff;
      cmd_push       = 1'b0;
      cmd_data       = '0;
      store_wr       = '0;

      if (fire && is_data) begin
         if (room) begin
            store_wr.en     = 1'b1;
            store_wr.slot   = fsq_pkg::CMD_SLOT_W'(stage_slot_ff);
            store_wr.offset = fsq_pkg::CMD_OFF_W'(load_count_ff);
            store_wr.data   = req_payload.data_byte;
            len_now         = load_count_ff + 1'b1;
            // a new chunk opens on every DATA_BYTES-th byte
            chunks_now      = load_chunks_ff + {7'd0, (load_sub_ff == '0)};
            load_sub_in     = (load_sub_ff == SUB_W'(DATA_BYTES - 1)) ? '0
                                                                      : load_sub_ff + 1'b1;
         end else begin
            over_now = 1'b1;
         end
         load_count_in  = len_now;
         load_chunks_in = chunks_now;
         load_over_in   = over_now;

         if (req_payload.last_byte) begin
            load_count_in       = '0;
            load_sub_in         = '0;
            load_chunks_in      = '0;
            load_over_in        = 1'b0;
            cmd_push            = 1'b1;
            cmd_data.has_status = 1'b1;
            if (over_now) begin
               cmd_data.status_kind = fsq_pkg::KIND_LONG;
            end else if (!sending_ff) begin
               // staging becomes active, old active becomes staging
               swap                 = 1'b1;
               stage_slot_in        = active_slot_ff;
               active_slot_in       = stage_slot_ff;
               act_len_in           = len_now;
               offset_in            = '0;
               chunk_idx_in         = '0;
               chunk_tot_in         = chunks_now;
               sending_in           = 1'b1;
               cmd_data.status_kind = fsq_pkg::KIND_ACCEPT;
               cmd_data.has_pkt     = 1'b1;
               cmd_data.slot        = fsq_pkg::CMD_SLOT_W'(stage_slot_ff);
               cmd_data.dlen        = fsq_pkg::DLEN_W'(chunk_len(len_now, '0));
               cmd_data.chunk_tot   = chunks_now;
               cmd_data.seq         = seq_ff;
            end else if (q_count_ff == CNT_W'(QUEUE_DEPTH)) begin
               cmd_data.status_kind = fsq_pkg::KIND_FULL;
            end else begin
               // queue the staging slot, take a fresh one from the pool
               swap                 = 1'b1;
               q_slot_in[push_idx]  = stage_slot_ff;
               q_len_in[push_idx]   = len_now;
               q_tot_in[push_idx]   = chunks_now;
               q_count_in           = q_count_ff + 1'b1;
               stage_slot_in        = free_ff[0];
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  free_in[i] = free_ff[i+1];
               end
               cmd_data.status_kind = fsq_pkg::KIND_ACCEPT;
            end
         end
      end else if (fire && sending_ff) begin
         if (next_off < SUM_W'(act_len_ff)) begin
            chunk_idx_in       = chunk_idx_ff + 8'd1;
            offset_in          = OFF_W'(next_off);
            cmd_push           = 1'b1;
            cmd_data.has_pkt   = 1'b1;
            cmd_data.slot      = fsq_pkg::CMD_SLOT_W'(active_slot_ff);
            cmd_data.offset    = fsq_pkg::CMD_OFF_W'(next_off);
            cmd_data.dlen      = fsq_pkg::DLEN_W'(chunk_len(act_len_ff, next_off));
            cmd_data.chunk_idx = chunk_idx_ff + 8'd1;
            cmd_data.chunk_tot = chunk_tot_ff;
            cmd_data.seq       = seq_ff;
         end else begin
            seq_in     = seq_next;
            sending_in = 1'b0;
            if (q_count_ff != '0) begin
               // oldest queued frame goes active, old active returns to the pool
               active_slot_in                = q_slot_ff[0];
               act_len_in                    = q_len_ff[0];
               chunk_tot_in                  = q_tot_ff[0];
               chunk_idx_in                  = '0;
               offset_in                     = '0;
               sending_in                    = 1'b1;
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  q_slot_in[i] = q_slot_ff[i+1];
                  q_len_in[i]  = q_len_ff[i+1];
                  q_tot_in[i]  = q_tot_ff[i+1];
               end
               free_in[free_cnt[RING_W-1:0]] = active_slot_ff;
               q_count_in                    = q_count_ff - 1'b1;
               cmd_push                      = 1'b1;
               cmd_data.has_pkt              = 1'b1;
               cmd_data.slot                 = fsq_pkg::CMD_SLOT_W'(q_slot_ff[0]);
               cmd_data.dlen                 = fsq_pkg::DLEN_W'(chunk_len(q_len_ff[0], '0));
               cmd_data.chunk_tot            = q_tot_ff[0];
               cmd_data.seq                  = seq_next;
            end
         end
      end
   end

   assign hazard_in = swap || (hazard_ff && !(back_idle && cmd_empty));

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_slot_ff  <= SLOT_W'(0);
         active_slot_ff <= SLOT_W'(1);
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            free_ff[i] <= SLOT_W'(i + 2);
         end
         q_count_ff     <= '0;
         sending_ff     <= 1'b0;
         chunk_idx_ff   <= '0;
         chunk_tot_ff   <= '0;
         act_len_ff     <= '0;
         offset_ff      <= '0;
         seq_ff         <= '0;
         load_count_ff  <= '0;
         load_sub_ff    <= '0;
         load_chunks_ff <= '0;
         load_over_ff   <= 1'b0;
         hazard_ff      <= 1'b0;
      end else begin
         stage_slot_ff  <= stage_slot_in;
         active_slot_ff <= active_slot_in;
         free_ff        <= free_in;
         q_count_ff     <= q_count_in;
         sending_ff     <= sending_in;
         chunk_idx_ff   <= chunk_idx_in;
         chunk_tot_ff   <= chunk_tot_in;
         act_len_ff     <= act_len_in;
         offset_ff      <= offset_in;
         seq_ff         <= seq_in;
         load_count_ff  <= load_count_in;
         load_sub_ff    <= load_sub_in;
         load_chunks_ff <= load_chunks_in;
         load_over_ff   <= load_over_in;
         hazard_ff      <= hazard_in;
      end
   end

   always_ff @(posedge clock) begin
      q_slot_ff <= q_slot_in;
      q_len_ff  <= q_len_in;
      q_tot_ff  <= q_tot_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_slots_apart: assert property (@(posedge clock) disable iff (reset)
      stage_slot_ff != active_slot_ff)
      else $error("staging and active share a slot");

   a_pkt_sending: assert property (@(posedge clock) disable iff (reset)
      cmd_push && cmd_data.has_pkt |=> sending_ff)
      else $error("packet issued without a frame in flight");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command pushed into full queue");
`endif

endmodule

/* rtl/core/fsq_back.sv */
`timescale 1ns / 1ps

module fsq_back #(
   parameter int DATA_BYTES = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data,
   input  logic                     cmd_empty,
   input  fsq_pkg::cmd_type         cmd_data,
   output logic                     cmd_pop,
   output logic                     back_idle,
   output fsq_pkg::store_rd_type    store_rd,
   input  logic [7:0]               rd_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output fsq_pkg::rsp_payload_type rsp_payload
);

   localparam int POS_W = $clog2(fsq_pkg::HDR_BYTES + DATA_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(fsq_pkg::HDR_BYTES + DATA_BYTES - 1);

   fsq_pkg::back_state_type state_ff, state_in;
   fsq_pkg::cmd_type        cmd_ff, cmd_in;
   logic [7:0]              ptype_ff;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [fsq_pkg::CMD_OFF_W-1:0] rd_off_ff, rd_off_in;

   // output beat register; byte comes from the store read register when s1_mem_ff
   logic       s1_valid_ff;
   logic [1:0] s1_kind_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_mem_ff;
   logic       s1_last_ff;

   logic       adv;
   logic       emit;
   logic [1:0] emit_kind;
   logic [7:0] emit_byte;
   logic       emit_mem;
   logic       emit_last;
   logic [POS_W-1:0] data_i;

   assign adv       = !s1_valid_ff || rsp_ready;
   assign back_idle = (state_ff == fsq_pkg::BK_IDLE);
   assign data_i    = pos_ff - POS_W'(fsq_pkg::HDR_BYTES);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsq_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               state_in = cmd_data.has_status ? fsq_pkg::BK_STATUS : fsq_pkg::BK_PKT;
            end
         end
         fsq_pkg::BK_STATUS: begin
            if (adv) begin
               state_in = cmd_ff.has_pkt ? fsq_pkg::BK_PKT : fsq_pkg::BK_IDLE;
            end
         end
         fsq_pkg::BK_PKT: begin
            if (adv && pos_ff == POS_LAST) begin
               state_in = fsq_pkg::BK_IDLE;
            end
         end
         default: state_in = fsq_pkg::BK_IDLE;
      endcase
   end

   // outputs and beat generation
   always_comb begin
      cmd_pop   = 1'b0;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      rd_off_in = rd_off_ff;
      emit      = 1'b0;
      emit_kind = fsq_pkg::KIND_BYTE;
      emit_byte = '0;
      emit_mem  = 1'b0;
      emit_last = 1'b0;
      store_rd  = '0;
      case (state_ff)
         fsq_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd_data;
               pos_in    = '0;
               rd_off_in = cmd_data.offset;
            end
         end
         fsq_pkg::BK_STATUS: begin
            if (adv) begin
               emit      = 1'b1;
               emit_kind = cmd_ff.status_kind;
               emit_last = !cmd_ff.has_pkt;
            end
         end
         fsq_pkg::BK_PKT: begin
            if (adv) begin
               emit      = 1'b1;
               emit_last = (pos_ff == POS_LAST);
               pos_in    = pos_ff + 1'b1;
               if (pos_ff == POS_W'(fsq_pkg::HDR_TYPE)) begin
                  emit_byte = ptype_ff;
               end else if (pos_ff == POS_W'(fsq_pkg::HDR_SEQ)) begin
                  emit_byte = cmd_ff.seq;
               end else if (pos_ff == POS_W'(fsq_pkg::HDR_IDX)) begin
                  emit_byte = cmd_ff.chunk_idx;
               end else if (pos_ff == POS_W'(fsq_pkg::HDR_TOT)) begin
                  emit_byte = cmd_ff.chunk_tot;
               end else if (pos_ff < POS_W'(fsq_pkg::HDR_BYTES)) begin
                  emit_byte = 8'(cmd_ff.dlen);
               end else if (data_i < POS_W'(cmd_ff.dlen)) begin
                  emit_mem        = 1'b1;
                  store_rd.en     = 1'b1;
                  store_rd.slot   = cmd_ff.slot;
                  store_rd.offset = rd_off_ff;
                  rd_off_in       = rd_off_ff + 1'b1;
               end
               // past the data length: zero padding
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= fsq_pkg::BK_IDLE;
         ptype_ff    <= fsq_pkg::PTYPE_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            ptype_ff <= csr_wr_data;
         end
         if (adv) begin
            s1_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      rd_off_ff <= rd_off_in;
      if (adv) begin
         s1_kind_ff <= emit_kind;
         s1_byte_ff <= emit_byte;
         s1_mem_ff  <= emit_mem;
         s1_last_ff <= emit_last;
      end
   end

   assign rsp_valid            = s1_valid_ff;
   assign rsp_payload.out_kind = s1_kind_ff;
   assign rsp_payload.out_byte = s1_mem_ff ? rd_data : s1_byte_ff;
   assign rsp_payload.out_last = s1_last_ff;

endmodule

/* rtl/core/frame_segmenter_with_queue.sv */
`timescale 1ns / 1ps

// Channel   Ports                                 Beat
// ------------------------------------------------------------------------------
// request   req_valid / req_ready / req_payload   data byte or transmit-done event
// response  rsp_valid / rsp_ready / rsp_payload   packet byte or frame status
// csr       csr_wr_en / csr_wr_data               packet type (header byte 0)
//
// A request beat is taken whenever req_ready is high. A frame-end beat queues a
// command, as does a transmit-done beat when a further packet is due; the back end
// turns each into 1..DATA_BYTES+6 response beats at one per cycle while rsp_ready
// holds. req_ready drops while the command queue is full, and a data beat also waits
// after an accepted frame end until the back end has drained (the freed slot may
// still be in use). Reset is synchronous and clears all control state; the frame
// store is not cleared. rsp stalls hold the output beat and the store read register.

module frame_segmenter_with_queue #(
   parameter int DATA_BYTES      = 32,
   parameter int QUEUE_DEPTH     = 4,
   parameter int MAX_FRAME_BYTES = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fsq_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output fsq_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data
);

   // front -> command queue
   logic                  cmd_push;
   fsq_pkg::cmd_type      cmd_push_data;
   logic                  cmd_full;
   logic                  cmd_empty;

   // command queue -> back
   logic                  cmd_pop;
   fsq_pkg::cmd_type      cmd_head;
   logic                  back_idle;

   // frame store ports: front fills the staging slot, back reads the active slot
   fsq_pkg::store_wr_type store_wr;
   fsq_pkg::store_rd_type store_rd;
   logic [7:0]            store_rd_data;

   // Front: loads bytes, decides accept/reject, tracks slots, queue and chunk position.
   fsq_front #(
      .DATA_BYTES      (DATA_BYTES),
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_full    (cmd_full),
      .cmd_empty   (cmd_empty),
      .back_idle   (back_idle),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_push_data),
      .store_wr    (store_wr)
   );

   // Short command queue decoupling the two halves.
   fsq_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (cmd_empty),
      .full      (cmd_full)
   );

   // Frame store: one slot each for staging, active and every queue entry.
   fsq_store #(
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd      (store_rd),
      .rd_data (store_rd_data)
   );

   // Back: renders status beats and packets, one beat per cycle while rsp_ready allows.
   fsq_back #(
      .DATA_BYTES (DATA_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_empty   (cmd_empty),
      .cmd_data    (cmd_head),
      .cmd_pop     (cmd_pop),
      .back_idle   (back_idle),
      .store_rd    (store_rd),
      .rd_data     (store_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
